// ===== hw/rtl/nps_pkg.sv =====
// Shared types and constants for the nearest polyline segment query unit.
// Holds table sizes, datapath widths, operation and status codes, and the
// transfer structs. No dependencies.
`timescale 1ns / 1ps

package nps_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int COORD_BITS   = 24;
    localparam int DIFF_W       = COORD_BITS + 1;
    localparam int SQ_W         = 2 * DIFF_W;
    localparam int LEN_W        = DIFF_W;
    localparam int DIR_W        = 17;
    localparam int FRAC_W       = 15;
    localparam int NUM_W        = DIFF_W + FRAC_W;
    localparam int PROD_W       = DIFF_W + DIR_W;
    localparam int DOT_W        = PROD_W + 1;
    localparam int RAD_W        = 48;
    localparam int IT_W         = $clog2(NUM_W);
    localparam int VIDX_W       = 10;
    localparam int PADDR_W      = 4;

    localparam logic [DIR_W-1:0] ONE_Q15    = DIR_W'(32768);
    localparam logic [RAD_W-1:0] RADIUS_RST = RAD_W'(589824);
    localparam logic             REG_RADIUS = 1'b0;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] KIND_CLEAR  = 2'd0;
    localparam logic [1:0] KIND_APPEND = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;
    localparam logic [1:0] KIND_NOP    = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_ORPHAN = 2'd2;

    typedef struct packed {
        logic [1:0]                   operation;
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic [15:0]                  lane_width;
        logic [15:0]                  lane_tag;
        logic                         starts_lane;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        status;
        logic              lane_found;
        logic [15:0]       nearest_lane;
        logic [23:0]       lane_distance;
        logic              vertex_found;
        logic [VIDX_W-1:0] vertex_index;
        logic [RAD_W-1:0]  vertex_distance_sq;
    } out_item_t;

    typedef struct packed {
        logic [1:0]                   kind;
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic [15:0]                  lane_width;
        logic [15:0]                  lane_tag;
        logic                         starts_lane;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } queue_out_t;

    typedef struct packed {
        logic             busy;
        logic [CNT_W-1:0] count;
    } core_stat_t;

endpackage

// ===== hw/rtl/nps_front.sv =====
// Front end: accepts input transfers, decodes the operation into a command
// and holds it in a two-entry queue for the execution core. Uses nps_pkg.
`timescale 1ns / 1ps

module nps_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  nps_pkg::in_item_t   in_data,
    input  logic                pop,
    output nps_pkg::queue_out_t q
);
    import nps_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    logic       push;
    cmd_t       cmd_in;

    assign in_stall = (fill_reg == 2'd2);
    assign push     = in_valid && !in_stall;

    always_comb
    begin
        cmd_in.point_x     = in_data.point_x;
        cmd_in.point_y     = in_data.point_y;
        cmd_in.lane_width  = in_data.lane_width;
        cmd_in.lane_tag    = in_data.lane_tag;
        cmd_in.starts_lane = in_data.starts_lane;
        case (in_data.operation)
            OP_CLEAR:  cmd_in.kind = KIND_CLEAR;
            OP_APPEND: cmd_in.kind = KIND_APPEND;
            OP_QUERY:  cmd_in.kind = KIND_QUERY;
            default:   cmd_in.kind = KIND_NOP;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                fill_reg <= fill_reg + 2'd1;
            else if (pop && !push)
                fill_reg <= fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= cmd_in;
    end

    assign q.valid = (fill_reg != 2'd0);
    assign q.cmd   = slot_reg[rd_ptr_reg];

endmodule

// ===== hw/rtl/nps_core.sv =====
// Execution core: vertex and segment tables, append with iterative square
// root and division, and the segment and vertex search sequencer with its
// output register. Uses nps_pkg.
`timescale 1ns / 1ps

module nps_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  nps_pkg::queue_out_t          q,
    output logic                         pop,
    input  logic [nps_pkg::RAD_W-1:0]    radius,
    output logic                         out_valid,
    input  logic                         out_stall,
    output nps_pkg::out_item_t           out_data,
    output nps_pkg::core_stat_t          stat
);
    import nps_pkg::*;

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_APP_RD   = 5'd1;
    localparam logic [4:0] S_APP_WR   = 5'd2;
    localparam logic [4:0] S_APP_SQ   = 5'd3;
    localparam logic [4:0] S_APP_ADD  = 5'd4;
    localparam logic [4:0] S_SQRT     = 5'd5;
    localparam logic [4:0] S_DIV_INIT = 5'd6;
    localparam logic [4:0] S_DIV      = 5'd7;
    localparam logic [4:0] S_APP_SEG  = 5'd8;
    localparam logic [4:0] S_Q_RD     = 5'd9;
    localparam logic [4:0] S_Q_MUL    = 5'd10;
    localparam logic [4:0] S_Q_CMP    = 5'd11;
    localparam logic [4:0] S_V_RD     = 5'd12;
    localparam logic [4:0] S_V_MUL    = 5'd13;
    localparam logic [4:0] S_V_CMP    = 5'd14;
    localparam logic [4:0] S_DONE     = 5'd15;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic [15:0]                  width;
        logic [15:0]                  tag;
        logic                         start;
    } vert_t;

    typedef struct packed {
        logic signed [DIR_W-1:0] cosv;
        logic signed [DIR_W-1:0] sinv;
        logic [LEN_W-1:0]        len;
        logic                    valid;
    } seg_t;

    vert_t vmem [MAX_VERTICES];
    seg_t  smem [MAX_VERTICES];
    vert_t vrd_reg;
    seg_t  srd_reg;

    logic              vm_we, sm_we, rd_en;
    logic [ADDR_W-1:0] vm_waddr, sm_waddr, raddr;
    vert_t             vm_wdata;
    seg_t              sm_wdata;

    logic [4:0]             state_reg, state_next;
    cmd_t                   cmd_reg, cmd_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CNT_W-1:0]       idx_reg, idx_next;
    logic [CNT_W-1:0]       lstart_reg, lstart_next;
    logic [CNT_W-1:0]       vstart_reg, vstart_next;
    out_item_t              res_reg, res_next;
    logic [DOT_W-1:0]       best_reg, best_next;
    logic signed [DIFF_W-1:0] dx_reg, dx_next, dy_reg, dy_next;
    logic [SQ_W-1:0]        sqa_reg, sqa_next, sqb_reg, sqb_next;
    logic [SQ_W-1:0]        rad_reg, rad_next;
    logic [LEN_W-1:0]       root_reg, root_next;
    logic [LEN_W:0]         rem_reg, rem_next;
    logic [LEN_W-1:0]       len_reg, len_next;
    logic [NUM_W-1:0]       num_reg, num_next;
    logic [LEN_W-1:0]       drem_reg, drem_next;
    logic [IT_W-1:0]        it_reg, it_next;
    logic                   sel_reg, sel_next;
    logic signed [DIR_W-1:0] cos_reg, cos_next, sin_reg, sin_next;
    logic signed [PROD_W-1:0] pic_reg, pic_next, pis_reg, pis_next;
    logic signed [PROD_W-1:0] pcc_reg, pcc_next, pcs_reg, pcs_next;
    logic                   out_valid_reg, out_valid_next;
    out_item_t              out_data_reg, out_data_next;

    logic signed [DIFF_W-1:0] ddx, ddy, dsel;
    logic signed [SQ_W-1:0]   sq_x, sq_y;
    logic [LEN_W+2:0]         rem_t;
    logic [LEN_W+2:0]         trial;
    logic [LEN_W:0]           drem_t;
    logic                     qbit;
    logic [DIFF_W-1:0]        dmag;
    logic signed [DIR_W-1:0]  qv;
    logic signed [DOT_W-1:0]  ip, cp;
    logic [DOT_W-1:0]         acp;
    logic [DOT_W:0]           rnd;
    logic                     hit;
    logic [SQ_W-1:0]          dsum;
    logic [RAD_W-1:0]         dsat;
    logic [31:0]              vidx;
    logic                     last;

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        lstart_next    = lstart_reg;
        vstart_next    = vstart_reg;
        res_next       = res_reg;
        best_next      = best_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        sqa_next       = sqa_reg;
        sqb_next       = sqb_reg;
        rad_next       = rad_reg;
        root_next      = root_reg;
        rem_next       = rem_reg;
        len_next       = len_reg;
        num_next       = num_reg;
        drem_next      = drem_reg;
        it_next        = it_reg;
        sel_next       = sel_reg;
        cos_next       = cos_reg;
        sin_next       = sin_reg;
        pic_next       = pic_reg;
        pis_next       = pis_reg;
        pcc_next       = pcc_reg;
        pcs_next       = pcs_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        pop            = 1'b0;
        vm_we          = 1'b0;
        sm_we          = 1'b0;
        rd_en          = 1'b0;
        vm_waddr       = count_reg[ADDR_W-1:0];
        sm_waddr       = count_reg[ADDR_W-1:0];
        raddr          = idx_reg[ADDR_W-1:0];
        vm_wdata       = '0;
        sm_wdata       = '0;

        ddx   = DIFF_W'(cmd_reg.point_x) - DIFF_W'(vrd_reg.x);
        ddy   = DIFF_W'(cmd_reg.point_y) - DIFF_W'(vrd_reg.y);
        sq_x  = dx_reg * dx_reg;
        sq_y  = dy_reg * dy_reg;
        rem_t = {rem_reg, rad_reg[SQ_W-1 -: 2]};
        trial = {1'b0, root_reg, 2'b01};
        drem_t = {drem_reg, num_reg[NUM_W-1]};
        qbit  = (drem_t >= {1'b0, len_reg});
        dsel  = sel_reg ? dy_reg : dx_reg;
        dmag  = dsel[DIFF_W-1] ? DIFF_W'(-dsel) : DIFF_W'(dsel);
        qv    = dsel[DIFF_W-1] ? -signed'({num_reg[DIR_W-2:0], qbit})
                               : signed'({num_reg[DIR_W-2:0], qbit});
        ip    = DOT_W'(pic_reg) + DOT_W'(pis_reg);
        cp    = DOT_W'(pcc_reg) - DOT_W'(pcs_reg);
        acp   = cp[DOT_W-1] ? DOT_W'(-cp) : DOT_W'(cp);
        rnd   = {1'b0, acp} + (DOT_W+1)'(1 << (FRAC_W - 1));
        hit   = srd_reg.valid && !ip[DOT_W-1]
                && (DOT_W'(ip) <= DOT_W'({srd_reg.len, FRAC_W'(0)}))
                && (acp <= DOT_W'({vrd_reg.width, FRAC_W'(0)}))
                && (!res_reg.lane_found || acp < best_reg);
        dsum  = sqa_reg + sqb_reg;
        dsat  = (dsum[SQ_W-1:RAD_W] != '0) ? '1 : dsum[RAD_W-1:0];
        vidx  = 32'(idx_reg - vstart_reg);
        last  = ((idx_reg + CNT_W'(1)) >= count_reg);

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (q.valid)
                begin
                    pop      = 1'b1;
                    cmd_next = q.cmd;
                    res_next = '0;
                    idx_next = '0;
                    case (q.cmd.kind)
                        KIND_CLEAR:
                        begin
                            count_next = '0;
                            state_next = S_DONE;
                        end
                        KIND_APPEND:
                        begin
                            if (count_reg == CNT_W'(MAX_VERTICES))
                            begin
                                res_next.status = ST_FULL;
                                state_next      = S_DONE;
                            end
                            else if (q.cmd.starts_lane)
                                state_next = S_APP_WR;
                            else if (count_reg == '0)
                            begin
                                res_next.status = ST_ORPHAN;
                                state_next      = S_DONE;
                            end
                            else
                                state_next = S_APP_RD;
                        end
                        KIND_QUERY:
                        begin
                            lstart_next = '0;
                            state_next  = (count_reg == '0) ? S_DONE : S_Q_RD;
                        end
                        default:
                            state_next = S_DONE;
                    endcase
                end
            end
            S_APP_RD:
            begin
                rd_en      = 1'b1;
                raddr      = ADDR_W'(count_reg - CNT_W'(1));
                state_next = S_APP_WR;
            end
            S_APP_WR:
            begin
                vm_we          = 1'b1;
                vm_wdata.x     = cmd_reg.point_x;
                vm_wdata.y     = cmd_reg.point_y;
                vm_wdata.width = cmd_reg.lane_width;
                vm_wdata.tag   = cmd_reg.starts_lane ? cmd_reg.lane_tag : vrd_reg.tag;
                vm_wdata.start = cmd_reg.starts_lane;
                sm_we          = 1'b1;
                sm_wdata.cosv  = signed'(ONE_Q15);
                sm_wdata.sinv  = '0;
                sm_wdata.len   = '0;
                sm_wdata.valid = 1'b0;
                dx_next        = DIFF_W'(cmd_reg.point_x) - DIFF_W'(vrd_reg.x);
                dy_next        = DIFF_W'(cmd_reg.point_y) - DIFF_W'(vrd_reg.y);
                if (cmd_reg.starts_lane)
                begin
                    count_next = count_reg + CNT_W'(1);
                    state_next = S_DONE;
                end
                else
                    state_next = S_APP_SQ;
            end
            S_APP_SQ:
            begin
                sqa_next   = SQ_W'(sq_x);
                sqb_next   = SQ_W'(sq_y);
                state_next = S_APP_ADD;
            end
            S_APP_ADD:
            begin
                rad_next   = sqa_reg + sqb_reg;
                root_next  = '0;
                rem_next   = '0;
                it_next    = '0;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                if (rem_t >= trial)
                begin
                    rem_next  = (LEN_W+1)'(rem_t - trial);
                    root_next = {root_reg[LEN_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_t[LEN_W:0];
                    root_next = {root_reg[LEN_W-2:0], 1'b0};
                end
                rad_next = {rad_reg[SQ_W-3:0], 2'b00};
                it_next  = it_reg + IT_W'(1);
                if (it_reg == IT_W'(LEN_W - 1))
                begin
                    len_next   = root_next;
                    sel_next   = 1'b0;
                    state_next = S_DIV_INIT;
                end
            end
            S_DIV_INIT:
            begin
                num_next   = {dmag, FRAC_W'(0)} + NUM_W'(len_reg >> 1);
                drem_next  = '0;
                it_next    = '0;
                state_next = (len_reg == '0) ? S_APP_SEG : S_DIV;
            end
            S_DIV:
            begin
                drem_next = qbit ? LEN_W'(drem_t - {1'b0, len_reg}) : LEN_W'(drem_t);
                num_next  = {num_reg[NUM_W-2:0], qbit};
                it_next   = it_reg + IT_W'(1);
                if (it_reg == IT_W'(NUM_W - 1))
                begin
                    if (sel_reg)
                    begin
                        sin_next   = qv;
                        state_next = S_APP_SEG;
                    end
                    else
                    begin
                        cos_next   = qv;
                        sel_next   = 1'b1;
                        state_next = S_DIV_INIT;
                    end
                end
            end
            S_APP_SEG:
            begin
                sm_we          = 1'b1;
                sm_waddr       = ADDR_W'(count_reg - CNT_W'(1));
                sm_wdata.cosv  = (len_reg == '0) ? signed'(ONE_Q15) : cos_reg;
                sm_wdata.sinv  = (len_reg == '0) ? '0 : sin_reg;
                sm_wdata.len   = len_reg;
                sm_wdata.valid = 1'b1;
                count_next     = count_reg + CNT_W'(1);
                state_next     = S_DONE;
            end
            S_Q_RD:
            begin
                rd_en      = 1'b1;
                state_next = S_Q_MUL;
            end
            S_Q_MUL:
            begin
                if (vrd_reg.start)
                    lstart_next = idx_reg;
                pic_next   = ddx * srd_reg.cosv;
                pis_next   = ddy * srd_reg.sinv;
                pcc_next   = ddy * srd_reg.cosv;
                pcs_next   = ddx * srd_reg.sinv;
                state_next = S_Q_CMP;
            end
            S_Q_CMP:
            begin
                if (hit)
                begin
                    res_next.lane_found    = 1'b1;
                    res_next.nearest_lane  = vrd_reg.tag;
                    res_next.lane_distance = rnd[FRAC_W +: 24];
                    best_next              = acp;
                    vstart_next            = lstart_reg;
                end
                idx_next = idx_reg + CNT_W'(1);
                if (last)
                begin
                    if (res_next.lane_found)
                    begin
                        idx_next   = vstart_next;
                        state_next = S_V_RD;
                    end
                    else
                        state_next = S_DONE;
                end
                else
                    state_next = S_Q_RD;
            end
            S_V_RD:
            begin
                rd_en      = 1'b1;
                state_next = S_V_MUL;
            end
            S_V_MUL:
            begin
                dx_next = ddx;
                dy_next = ddy;
                if (idx_reg != vstart_reg && vrd_reg.start)
                    state_next = S_DONE;
                else
                    state_next = S_V_CMP;
            end
            S_V_CMP:
            begin
                if (dsat <= radius
                    && (!res_reg.vertex_found || dsat < res_reg.vertex_distance_sq))
                begin
                    res_next.vertex_found       = 1'b1;
                    res_next.vertex_index       = vidx[VIDX_W-1:0];
                    res_next.vertex_distance_sq = dsat;
                end
                idx_next   = idx_reg + CNT_W'(1);
                state_next = last ? S_DONE : S_V_RD;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase

        if (state_reg == S_V_CMP)
        begin
            sqa_next = sqa_reg;
            sqb_next = sqb_reg;
        end
        if (state_reg == S_V_MUL)
        begin
            sqa_next = SQ_W'(ddx * ddx);
            sqb_next = SQ_W'(ddy * ddy);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        idx_reg      <= idx_next;
        lstart_reg   <= lstart_next;
        vstart_reg   <= vstart_next;
        res_reg      <= res_next;
        best_reg     <= best_next;
        dx_reg       <= dx_next;
        dy_reg       <= dy_next;
        sqa_reg      <= sqa_next;
        sqb_reg      <= sqb_next;
        rad_reg      <= rad_next;
        root_reg     <= root_next;
        rem_reg      <= rem_next;
        len_reg      <= len_next;
        num_reg      <= num_next;
        drem_reg     <= drem_next;
        it_reg       <= it_next;
        sel_reg      <= sel_next;
        cos_reg      <= cos_next;
        sin_reg      <= sin_next;
        pic_reg      <= pic_next;
        pis_reg      <= pis_next;
        pcc_reg      <= pcc_next;
        pcs_reg      <= pcs_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (vm_we)
            vmem[vm_waddr] <= vm_wdata;
        if (rd_en)
            vrd_reg <= vmem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (sm_we)
            smem[sm_waddr] <= sm_wdata;
        if (rd_en)
            srd_reg <= smem[raddr];
    end

    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;
    assign stat.busy  = (state_reg != S_IDLE);
    assign stat.count = count_reg;

endmodule

// ===== hw/rtl/nearest_polyline_segment_query_unit.sv =====
// Top level of the nearest polyline segment query unit: configuration port, front-end
// queue and execution core. Uses nps_pkg, nps_front and nps_core. A lane start append
// writes one vertex; a continuation append also runs an iterative square root and two
// divisions (zero length skips the divisions); a query scans every stored vertex, then,
// if a segment hits, the vertices of the lane that holds the best segment.
// Reset empties the table and loads the default pick radius; no clearing pass.
`timescale 1ns / 1ps

module nearest_polyline_segment_query_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  nps_pkg::in_item_t             in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output nps_pkg::out_item_t            out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [nps_pkg::PADDR_W-1:0]   paddr,
    input  logic [63:0]                   pwdata,
    output logic [63:0]                   prdata,
    output logic                          pready
);
    import nps_pkg::*;

    logic [RAD_W-1:0] radius_reg;
    queue_out_t       q;
    logic             pop;
    core_stat_t       stat;
    logic             cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[PADDR_W-1] == REG_RADIUS) ? 64'(radius_reg) : 64'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radius_reg <= RADIUS_RST;
        else if (cfg_write && paddr[PADDR_W-1] == REG_RADIUS)
            radius_reg <= pwdata[RAD_W-1:0];
    end

    nps_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .pop      (pop),
        .q        (q)
    );

    nps_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .q         (q),
        .pop       (pop),
        .radius    (radius_reg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .stat      (stat)
    );

    a_pop_has_entry: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q.valid)
        else $error("core took a command from an empty queue");

    a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> stat.busy)
        else $error("core did not start on a popped command");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stat.count <= CNT_W'(MAX_VERTICES))
        else $error("vertex count beyond table depth");

    a_vertex_needs_lane: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.lane_found |-> !out_data.vertex_found)
        else $error("vertex reported without a lane");

endmodule

// ===== test/tb_nearest_polyline_segment_query_unit.sv =====
// Testbench for the nearest polyline segment query unit: directed table and random
// transfers checked against a behavioral predictor of the vertex table and queries.
// Depends on nps_pkg and nearest_polyline_segment_query_unit.
`timescale 1ns / 1ps

module tb_nearest_polyline_segment_query_unit;
    import nps_pkg::*;

    localparam int NV = MAX_VERTICES;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    in_item_t in_data;
    logic out_valid;
    logic out_stall;
    out_item_t out_data;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic pready;

    nearest_polyline_segment_query_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    longint tbl_x [NV];
    longint tbl_y [NV];
    longint tbl_cos [NV];
    longint tbl_sin [NV];
    longint unsigned tbl_len [NV];
    int unsigned tbl_w [NV];
    int unsigned tbl_tag [NV];
    bit tbl_start [NV];
    bit tbl_seg [NV];
    int unsigned n_vertices;
    longint unsigned pick_radius_sq;

    out_item_t expected_q [$];
    int errors;
    bit no_idle;
    bit hold_off;

    function automatic longint unsigned absval(longint v);
        return v < 0 ? longint'(-v) : v;
    endfunction

    function automatic longint unsigned dist_sq(longint a, longint b);
        longint unsigned ma;
        longint unsigned mb;
        ma = absval(a);
        mb = absval(b);
        if (ma >= 64'h8000_0000) ma = 64'h7FFF_FFFF;
        if (mb >= 64'h8000_0000) mb = 64'h7FFF_FFFF;
        return ma * ma + mb * mb;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'h1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint unit_part(longint d, longint unsigned len);
        longint unsigned q;
        q = (absval(d) * 32768 + len / 2) / len;
        return d < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic out_item_t predict_lane_lookup(in_item_t it);
        out_item_t r;
        longint px;
        longint py;
        longint dx;
        longint dy;
        longint ip;
        longint cp;
        longint unsigned acp;
        longint unsigned best;
        longint unsigned d;
        longint unsigned vbest;
        bit found;
        bit vf;
        int unsigned best_seg;
        int unsigned best_start;
        int unsigned lane_start;
        int unsigned vidx;
        int unsigned p;
        r = '0;
        px = it.point_x;
        py = it.point_y;
        case (it.operation)
            OP_CLEAR: n_vertices = 0;
            OP_APPEND:
            begin
                p = n_vertices;
                if (p >= NV) r.status = ST_FULL;
                else if (!it.starts_lane && p == 0) r.status = ST_ORPHAN;
                else
                begin
                    r.status = ST_OK;
                    tbl_x[p] = px;
                    tbl_y[p] = py;
                    tbl_w[p] = it.lane_width;
                    tbl_start[p] = it.starts_lane;
                    tbl_seg[p] = 0;
                    tbl_cos[p] = 32768;
                    tbl_sin[p] = 0;
                    tbl_len[p] = 0;
                    if (it.starts_lane) tbl_tag[p] = it.lane_tag;
                    else
                    begin
                        dx = tbl_x[p] - tbl_x[p-1];
                        dy = tbl_y[p] - tbl_y[p-1];
                        d = int_sqrt(dist_sq(dx, dy));
                        tbl_tag[p] = tbl_tag[p-1];
                        tbl_len[p-1] = d;
                        tbl_cos[p-1] = d == 0 ? 32768 : unit_part(dx, d);
                        tbl_sin[p-1] = d == 0 ? 0 : unit_part(dy, d);
                        tbl_seg[p-1] = 1;
                    end
                    n_vertices = p + 1;
                end
            end
            OP_QUERY:
            begin
                found = 0;
                best = 0;
                best_seg = 0;
                best_start = 0;
                lane_start = 0;
                for (int unsigned i = 0; i < n_vertices; i++)
                begin
                    if (tbl_start[i]) lane_start = i;
                    if (!tbl_seg[i]) continue;
                    dx = px - tbl_x[i];
                    dy = py - tbl_y[i];
                    ip = dx * tbl_cos[i] + dy * tbl_sin[i];
                    cp = dy * tbl_cos[i] - dx * tbl_sin[i];
                    if (ip < 0 || longint'(ip) > longint'(tbl_len[i] << 15)) continue;
                    acp = absval(cp);
                    if (acp > (longint'(tbl_w[i]) << 15)) continue;
                    if (!found || acp < best)
                    begin
                        found = 1;
                        best = acp;
                        best_seg = i;
                        best_start = lane_start;
                    end
                end
                if (found)
                begin
                    r.lane_found = 1;
                    r.nearest_lane = tbl_tag[best_seg][15:0];
                    r.lane_distance = 24'((best + (64'h1 << 14)) >> 15);
                    vf = 0;
                    vbest = 0;
                    vidx = 0;
                    for (int unsigned j = best_start; j < n_vertices; j++)
                    begin
                        if (j != best_start && tbl_start[j]) break;
                        d = dist_sq(px - tbl_x[j], py - tbl_y[j]);
                        if (d > 64'hFFFF_FFFF_FFFF) d = 64'hFFFF_FFFF_FFFF;
                        if (d > pick_radius_sq) continue;
                        if (!vf || d < vbest)
                        begin
                            vf = 1;
                            vbest = d;
                            vidx = j - best_start;
                        end
                    end
                    if (vf)
                    begin
                        r.vertex_found = 1;
                        r.vertex_index = vidx[VIDX_W-1:0];
                        r.vertex_distance_sq = vbest[RAD_W-1:0];
                    end
                end
            end
            default: r.status = ST_OK;
        endcase
        return r;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #400ms;
        $display("simulation failed");
        $finish;
    end

    task automatic idle_gap();
        int n;
        n = $urandom_range(1, 16);
        repeat (n) @(posedge clk);
    endtask

    task automatic send(in_item_t it);
        if (!no_idle && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            idle_gap();
        end
        in_valid <= 1'b1;
        in_data <= it;
        expected_q.push_back(predict_lane_lookup(it));
        do @(posedge clk); while (in_stall);
    endtask

    task automatic write_radius(longint unsigned v);
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {REG_RADIUS, 3'b000};
        pwdata <= 64'(v);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        pick_radius_sq = v & 64'hFFFF_FFFF_FFFF;
    endtask

    function automatic in_item_t mk(logic [1:0] op, int x, int y, int w, int tag, bit s);
        in_item_t it;
        it.operation = op;
        it.point_x = x[23:0];
        it.point_y = y[23:0];
        it.lane_width = w[15:0];
        it.lane_tag = tag[15:0];
        it.starts_lane = s;
        return it;
    endfunction

    function automatic in_item_t rand_item(int cx, int cy, int spread);
        in_item_t it;
        int r;
        it = $bits(in_item_t)'({$urandom, $urandom, $urandom});
        r = $urandom_range(0, 99);
        if (r < 3) it.operation = OP_CLEAR;
        else if (r < 6) it.operation = OP_UNUSED;
        else if (r < 55) it.operation = OP_APPEND;
        else it.operation = OP_QUERY;
        if (r < 90)
        begin
            it.point_x = 24'(cx + int'($urandom_range(0, 2 * spread)) - spread);
            it.point_y = 24'(cy + int'($urandom_range(0, 2 * spread)) - spread);
            it.lane_width = 16'($urandom_range(0, 4000));
            it.starts_lane = ($urandom_range(0, 5) == 0);
        end
        return it;
    endfunction

    // Directed rows: operation fields plus a typed result where it is obvious.
    typedef struct {
        in_item_t  item;
        bit        typed;
        out_item_t result;
    } dir_row_t;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!no_idle && !hold_off && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
            end
            else if (hold_off)
                out_stall <= 1'b1;
            else if (out_stall && $urandom_range(0, 3) != 0 && !no_idle)
                out_stall <= 1'b1;
            else
                out_stall <= 1'b0;
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("unexpected result transfer");
                    errors++;
                end
                else
                begin
                    out_item_t e;
                    e = expected_q.pop_front();
                    if (out_data.status !== e.status)
                    begin
                        $error("status exp %0d got %0d", e.status, out_data.status);
                        errors++;
                    end
                    if (out_data.lane_found !== e.lane_found)
                    begin
                        $error("lane_found exp %0d got %0d", e.lane_found,
                            out_data.lane_found);
                        errors++;
                    end
                    if (out_data.nearest_lane !== e.nearest_lane)
                    begin
                        $error("nearest_lane exp %0d got %0d", e.nearest_lane,
                            out_data.nearest_lane);
                        errors++;
                    end
                    if (out_data.lane_distance !== e.lane_distance)
                    begin
                        $error("lane_distance exp %0d got %0d", e.lane_distance,
                            out_data.lane_distance);
                        errors++;
                    end
                    if (out_data.vertex_found !== e.vertex_found)
                    begin
                        $error("vertex_found exp %0d got %0d", e.vertex_found,
                            out_data.vertex_found);
                        errors++;
                    end
                    if (out_data.vertex_index !== e.vertex_index)
                    begin
                        $error("vertex_index exp %0d got %0d", e.vertex_index,
                            out_data.vertex_index);
                        errors++;
                    end
                    if (out_data.vertex_distance_sq !== e.vertex_distance_sq)
                    begin
                        $error("vertex_distance_sq exp %0d got %0d",
                            e.vertex_distance_sq, out_data.vertex_distance_sq);
                        errors++;
                    end
                end
            end
        end
    end

    initial
    begin
        dir_row_t rows [$];
        dir_row_t row;
        out_item_t ok;
        in_item_t it;
        int cx;
        int cy;
        int spread;
        int wait_n;
        errors = 0;
        no_idle = 0;
        hold_off = 0;
        n_vertices = 0;
        pick_radius_sq = RADIUS_RST;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        ok = '0;
        ok.status = ST_ORPHAN;
        rows.push_back('{mk(OP_APPEND, 0, 0, 0, 0, 0), 1, ok});
        ok.status = ST_OK;
        rows.push_back('{mk(OP_QUERY, 0, 0, 0, 0, 0), 1, ok});
        rows.push_back('{mk(OP_UNUSED, -1, -1, 65535, 65535, 1), 1, ok});
        rows.push_back('{mk(OP_APPEND, 0, 0, 256, 7, 1), 1, ok});
        rows.push_back('{mk(OP_APPEND, 2560, 0, 512, 99, 0), 1, ok});
        rows.push_back('{mk(OP_APPEND, 2560, 2560, 65535, 0, 0), 1, ok});
        rows.push_back('{mk(OP_APPEND, 2560, 2560, 100, 0, 0), 1, ok});
        rows.push_back('{mk(OP_APPEND, 2000, 3000, 300, 0, 0), 1, ok});
        rows.push_back('{mk(OP_QUERY, 1280, 100, 0, 0, 0), 0, ok});
        rows.push_back('{mk(OP_QUERY, 2560, 1280, 0, 0, 0), 0, ok});
        rows.push_back('{mk(OP_QUERY, -256, 0, 0, 0, 0), 0, ok});
        rows.push_back('{mk(OP_QUERY, 2560, 0, 0, 0, 0), 0, ok});
        rows.push_back('{mk(OP_APPEND, -8388608, -8388608, 65535, 65535, 1), 1, ok});
        rows.push_back('{mk(OP_APPEND, 8388607, 8388607, 65535, 1, 0), 1, ok});
        rows.push_back('{mk(OP_APPEND, 8388607, -8388608, 0, 1, 0), 1, ok});
        rows.push_back('{mk(OP_QUERY, 0, 0, 0, 0, 0), 0, ok});
        rows.push_back('{mk(OP_QUERY, 8388607, 8388607, 0, 0, 0), 0, ok});
        rows.push_back('{mk(OP_QUERY, -8388608, 0, 0, 0, 0), 0, ok});
        rows.push_back('{mk(OP_CLEAR, 5, 5, 5, 5, 1), 1, ok});
        rows.push_back('{mk(OP_QUERY, 0, 0, 0, 0, 0), 1, ok});
        foreach (rows[k])
        begin
            row = rows[k];
            send(row.item);
            if (row.typed && expected_q[$] != row.result)
            begin
                $error("directed row %0d: predictor disagrees with table", k);
                errors++;
            end
        end

        // Several short lanes, then a query inside one of them.
        write_radius(64'hFFFF_FFFF_FFFF);
        for (int k = 0; k < 40; k++)
        begin
            it = mk(OP_APPEND, k * 64, (k % 7) * 32, 200, k / 10, (k % 10) == 0);
            send(it);
        end
        send(mk(OP_APPEND, 0, 0, 0, 0, 1));
        send(mk(OP_QUERY, 15 * 64 + 10, 40, 0, 0, 0));
        send(mk(OP_CLEAR, 0, 0, 0, 0, 0));
        write_radius(0);

        fork
            begin
                hold_off = 1;
                repeat (300) @(posedge clk);
                hold_off = 0;
            end
            begin
                for (int k = 0; k < 12; k++)
                    send(mk(k == 0 ? OP_APPEND : OP_QUERY, k, k, 10, 3, 1));
            end
        join

        for (int ph = 0; ph < 3; ph++)
        begin
            if (ph == 1) write_radius(64'd589824);
            if (ph == 2)
            begin
                write_radius(64'(($urandom_range(1, 40000)) * 65536));
                no_idle = 0;
            end
            send(mk(OP_CLEAR, 0, 0, 0, 0, 0));
            cx = int'($urandom_range(0, 16000)) - 8000;
            cy = int'($urandom_range(0, 16000)) - 8000;
            spread = ph == 0 ? 3000 : 800;
            send(mk(OP_APPEND, cx, cy, 500, $urandom_range(0, 65535), 1));
            for (int k = 0; k < 70; k++)
            begin
                if (ph == 2 && k > 50) no_idle = 1;
                send(rand_item(cx, cy, spread));
            end
        end
        in_valid <= 1'b0;

        wait_n = 0;
        while (expected_q.size() != 0 && wait_n < 2000000)
        begin
            @(posedge clk);
            wait_n++;
        end
        repeat (3500) @(posedge clk);
        if (errors == 0 && expected_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
